// ----- sv/lps_pkg.sv -----
package lps_pkg;

    // pivot table geometry, fixed by the 10-bit column field
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = 10;
    localparam int ROW_W       = 16;
    localparam int COUNT_W     = 11;

    localparam logic [ADDR_W-1:0] OFFSET_MAX = 10'd1023;

    // input commands
    localparam logic [1:0] CMD_ENTRY = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result kinds
    localparam logic RK_VERDICT = 1'b0;
    localparam logic RK_QUERY   = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } lps_state_t;

endpackage

// ----- sv/lps_row_track.sv -----
module lps_row_track #(
    parameter int COLS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [lps_pkg::ADDR_W-1:0]  column,
    input  logic                        last_in_row,
    output logic [lps_pkg::ADDR_W-1:0]  end_column,
    output logic [lps_pkg::ADDR_W-1:0]  end_offset,
    output logic [$clog2(COLS+1)-1:0]   end_weight
);

    localparam int CNT_W = $clog2(COLS + 1);

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [lps_pkg::ADDR_W-1:0] min_col_reg;
    logic [lps_pkg::ADDR_W-1:0] min_col_next;
    logic [lps_pkg::ADDR_W-1:0] min_off_reg;
    logic [lps_pkg::ADDR_W-1:0] min_off_next;
    logic [31:0]                pos_wide;
    logic [lps_pkg::ADDR_W-1:0] pos_sat;
    logic                       take;

    // this entry becomes leftmost if it opens the row or beats the minimum
    always_comb
    begin
        pos_wide   = 32'(count_reg);
        pos_sat    = (pos_wide > 32'(lps_pkg::OFFSET_MAX)) ? lps_pkg::OFFSET_MAX
                                                           : pos_wide[lps_pkg::ADDR_W-1:0];
        take       = (count_reg == '0) || (column < min_col_reg);
        end_column = take ? column : min_col_reg;
        end_offset = take ? pos_sat : min_off_reg;
        end_weight = (32'(count_reg) < COLS) ? count_reg + CNT_W'(1) : count_reg;
    end

    always_comb
    begin
        count_next   = count_reg;
        min_col_next = min_col_reg;
        min_off_next = min_off_reg;
        if (step)
        begin
            if (last_in_row)
            begin
                count_next   = '0;
                min_col_next = '0;
                min_off_next = '0;
            end
            else
            begin
                count_next   = end_weight;
                min_col_next = end_column;
                min_off_next = end_offset;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            min_col_reg <= '0;
            min_off_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            min_col_reg <= min_col_next;
            min_off_reg <= min_off_next;
        end
    end

endmodule

// ----- sv/leftmost_pivot_selector.sv -----
// An entry that does not end a row is absorbed in the idle state. A row end
// or query holds the input in the lookup state while the table read returns;
// the result register loads as that state ends, once any held result is taken.
// Throughput: 1 entry per cycle inside a row. Reset and the clear command sweep
// the 1024-entry table, one entry per cycle, with in_ready low; only reset
// resets the running row state to empty.
module leftmost_pivot_selector #(
    parameter int COLS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   command,
    input  logic [lps_pkg::ROW_W-1:0]    row,
    input  logic [lps_pkg::ADDR_W-1:0]   column,
    input  logic                         last_in_row,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         result_kind,
    output logic [lps_pkg::ROW_W-1:0]    pivot_row,
    output logic [lps_pkg::ADDR_W-1:0]   pivot_column,
    output logic [lps_pkg::ADDR_W-1:0]   pivot_offset,
    output logic                         accepted,
    output logic                         found,
    output logic [lps_pkg::COUNT_W-1:0]  pivot_count
);

    // row weight saturates at COLS
    localparam int CNT_W = $clog2(COLS + 1);

    // one pivot table word per column
    typedef struct packed {
        logic                       has;
        logic [lps_pkg::ROW_W-1:0]  prow;
        logic [CNT_W-1:0]           weight;
    } entry_t;

    lps_pkg::lps_state_t state_reg;
    lps_pkg::lps_state_t state_next;

    // pivot table: synchronous read, one write port
    entry_t                         mem [lps_pkg::TABLE_DEPTH];
    entry_t                         rdata_reg;
    entry_t                         wr_data;
    logic [lps_pkg::ADDR_W-1:0]     rd_addr;
    logic [lps_pkg::ADDR_W-1:0]     wr_addr;
    logic                           wr_en;

    logic [lps_pkg::ADDR_W-1:0]     clr_cnt_reg;
    logic [lps_pkg::COUNT_W-1:0]    total_reg;
    logic [lps_pkg::COUNT_W-1:0]    total_next;

    // transaction held across the table lookup
    logic                           kind_reg;
    logic [lps_pkg::ROW_W-1:0]      row_reg;
    logic [lps_pkg::ADDR_W-1:0]     col_reg;
    logic [lps_pkg::ADDR_W-1:0]     off_reg;
    logic [CNT_W-1:0]               weight_reg;

    // result register
    logic                           out_valid_reg;
    logic                           kind_out_reg;
    logic [lps_pkg::ROW_W-1:0]      row_out_reg;
    logic [lps_pkg::ADDR_W-1:0]     col_out_reg;
    logic [lps_pkg::ADDR_W-1:0]     off_out_reg;
    logic                           acc_out_reg;
    logic                           found_out_reg;
    logic [lps_pkg::COUNT_W-1:0]    count_out_reg;

    logic                           in_fire;
    logic                           is_entry;
    logic                           is_query;
    logic                           is_clear;
    logic                           start_lookup;
    logic                           out_free;
    logic                           finish;
    logic                           col_ok;
    logic                           has_pivot;
    logic                           accept_v;
    logic                           new_pivot;

    logic [lps_pkg::ADDR_W-1:0]     end_column;
    logic [lps_pkg::ADDR_W-1:0]     end_offset;
    logic [CNT_W-1:0]               end_weight;

    assign in_fire      = in_valid && in_ready;
    assign is_entry     = (command == lps_pkg::CMD_ENTRY);
    assign is_query     = (command == lps_pkg::CMD_QUERY);
    assign is_clear     = (command == lps_pkg::CMD_CLEAR);
    // row end or query needs the table
    assign start_lookup = in_fire && ((is_entry && last_in_row) || is_query);
    assign out_free     = !out_valid_reg || out_ready;
    assign finish       = (state_reg == lps_pkg::ST_LOOKUP) && out_free;

    lps_row_track #(
        .COLS (COLS)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_fire && is_entry),
        .column      (column),
        .last_in_row (last_in_row),
        .end_column  (end_column),
        .end_offset  (end_offset),
        .end_weight  (end_weight)
    );

    // Lookup evaluation. The read is reissued at col_reg every cycle of the
    // lookup state, so a stalled output still sees fresh table data. Only
    // one lookup is ever in flight, so the write lands before the next read.
    always_comb
    begin
        col_ok    = (32'(col_reg) < COLS);
        has_pivot = rdata_reg.has && col_ok;
        accept_v  = (kind_reg == lps_pkg::RK_VERDICT) && col_ok
                    && (!rdata_reg.has || (weight_reg < rdata_reg.weight));
        new_pivot = accept_v && !rdata_reg.has;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lps_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                    state_next = lps_pkg::ST_IDLE;
            end
            lps_pkg::ST_IDLE:
            begin
                if (start_lookup)
                    state_next = lps_pkg::ST_LOOKUP;
                else if (in_fire && is_clear)
                    state_next = lps_pkg::ST_CLEAR;
            end
            lps_pkg::ST_LOOKUP:
            begin
                if (out_free)
                    state_next = lps_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lps_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs: handshake, table port, pivot count
    always_comb
    begin
        in_ready   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = col_reg;
        wr_data    = '{has: 1'b1, prow: row_reg, weight: weight_reg};
        rd_addr    = is_query ? column : end_column;
        total_next = total_reg;
        case (state_reg)
            lps_pkg::ST_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = clr_cnt_reg;
                wr_data    = '0;
                total_next = '0;
            end
            lps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire && is_clear)
                    total_next = '0;
            end
            lps_pkg::ST_LOOKUP:
            begin
                rd_addr = col_reg;
                if (out_free)
                begin
                    wr_en      = accept_v;
                    total_next = total_reg + lps_pkg::COUNT_W'(new_pivot);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lps_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            total_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            // wraps back to zero at the end of each sweep
            if (state_reg == lps_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + lps_pkg::ADDR_W'(1);
        end
    end

    // capture the transaction that needs a lookup
    always_ff @(posedge clk)
    begin
        if (start_lookup)
        begin
            kind_reg   <= is_query ? lps_pkg::RK_QUERY : lps_pkg::RK_VERDICT;
            row_reg    <= row;
            col_reg    <= is_query ? column : end_column;
            off_reg    <= is_query ? '0 : end_offset;
            weight_reg <= end_weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            kind_out_reg  <= kind_reg;
            row_out_reg   <= (kind_reg == lps_pkg::RK_QUERY)
                             ? (has_pivot ? rdata_reg.prow : '0) : row_reg;
            col_out_reg   <= col_reg;
            off_out_reg   <= off_reg;
            acc_out_reg   <= accept_v;
            found_out_reg <= (kind_reg == lps_pkg::RK_QUERY) && has_pivot;
            count_out_reg <= total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_out_reg;
    assign pivot_row    = row_out_reg;
    assign pivot_column = col_out_reg;
    assign pivot_offset = off_out_reg;
    assign accepted     = acc_out_reg;
    assign found        = found_out_reg;
    assign pivot_count  = count_out_reg;

endmodule

// ----- sv/lps_checker.sv -----
module lps_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [1:0]                   command,
    input logic                         out_valid,
    input logic                         result_kind,
    input logic [lps_pkg::ROW_W-1:0]    pivot_row,
    input logic [lps_pkg::ADDR_W-1:0]   pivot_offset,
    input logic                         accepted,
    input logic                         found
);

    // a query holds the input for its table lookup
    a_query_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == lps_pkg::CMD_QUERY)) |=> !in_ready)
        else $error("input taken during query lookup");

    // clear starts a table sweep
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == lps_pkg::CMD_CLEAR)) |=> !in_ready)
        else $error("input taken during table clear");

    a_verdict_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == lps_pkg::RK_VERDICT)) |-> !found)
        else $error("row verdict with found set");

    a_query_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == lps_pkg::RK_QUERY))
        |-> (!accepted && (pivot_offset == '0) && (found || (pivot_row == '0))))
        else $error("query answer fields inconsistent");

endmodule

bind leftmost_pivot_selector lps_checker u_lps_checker (.*);
